@@ hdl/gyro_bias_deadband_angle_integrator_macros.svh @@
// Assertion macros used by the gyro integrator core.
// Needs a clk and an active-low rst_n in the including module's scope.
`ifndef GYRO_BIAS_DEADBAND_ANGLE_INTEGRATOR_MACROS_SVH
`define GYRO_BIAS_DEADBAND_ANGLE_INTEGRATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GBDI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GBDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gbdi_pkg.sv @@
// Shared types, widths and constants for the gyro bias / deadband / angle integrator.
// No dependencies; used by gbdi_front, gbdi_core and the top level.
package gbdi_pkg;

  localparam int AXES        = 3;
  localparam int RAW_W       = 16;
  localparam int DT_W        = 16;
  localparam int Q_SHIFT     = 8;
  localparam int BIAS_W      = 24;
  localparam int RATE_W      = 25;
  localparam int ACC_W       = 56;
  localparam int DB_W        = 23;
  localparam int QMAG_W      = 24;
  localparam int QACC_W      = 25;
  localparam int RECIP_W     = 32;
  localparam int RECIP_SHIFT = 23;

  localparam logic [DB_W-1:0]  DEADBAND_RST = 23'd29257;
  localparam logic [ACC_W-1:0] ACC_MAX      = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN      = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_CAL  = 2'd0,
    MODE_MEAS = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  // Item handed from the front pipeline to the core: fields plus the
  // per-axis Q8 quotient magnitude floor(|raw| * 256 / CAL_SAMPLES).
  typedef struct packed {
    logic [1:0]                    mode;
    logic [AXES-1:0][RAW_W-1:0]    raw;
    logic [DT_W-1:0]               dt;
    logic [AXES-1:0][QMAG_W-1:0]   q_mag;
  } item_t;

  function automatic logic [RAW_W-1:0] raw_mag(input logic [RAW_W-1:0] raw);
    return raw[RAW_W-1] ? (~raw + 1'b1) : raw;
  endfunction

endpackage

@@ hdl/gyro_bias_deadband_angle_integrator.sv @@
// Gyro bias calibration, deadband and angle integration. One result per input
// transfer, one transfer per clock sustained while out_stall is low; a transfer passes
// the input, reciprocal-multiply and result registers in that order;
// the core updates its bias/angle state as each item is taken, hence the one-per-clock
// rate. out_stall backs up through the pipeline to in_stall; empty stages keep
// filling while a result waits. State is ready right after reset (no clearing pass).
// Depends on gbdi_pkg, gbdi_front and gbdi_core.
module gyro_bias_deadband_angle_integrator #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [22:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic signed [15:0]  in_raw_x,
  input  logic signed [15:0]  in_raw_y,
  input  logic signed [15:0]  in_raw_z,
  input  logic [15:0]         in_dt_ticks,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [24:0]  out_rate_x_q8,
  output logic signed [24:0]  out_rate_y_q8,
  output logic signed [24:0]  out_rate_z_q8,
  output logic signed [55:0]  out_angle_x_acc,
  output logic signed [55:0]  out_angle_y_acc,
  output logic signed [55:0]  out_angle_z_acc,
  output logic                out_calibrated
);

  logic            item_valid;
  logic            item_take;
  gbdi_pkg::item_t item;

  gbdi_front #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_raw_x    (in_raw_x),
    .in_raw_y    (in_raw_y),
    .in_raw_z    (in_raw_z),
    .in_dt_ticks (in_dt_ticks),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .item        (item)
  );

  gbdi_core #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .item_valid      (item_valid),
    .item_take       (item_take),
    .item            (item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rate_x_q8   (out_rate_x_q8),
    .out_rate_y_q8   (out_rate_y_q8),
    .out_rate_z_q8   (out_rate_z_q8),
    .out_angle_x_acc (out_angle_x_acc),
    .out_angle_y_acc (out_angle_y_acc),
    .out_angle_z_acc (out_angle_z_acc),
    .out_calibrated  (out_calibrated)
  );

endmodule

@@ hdl/gbdi_front.sv @@
// Front pipeline: input register, then per-axis reciprocal multiply for the
// calibration quotient. Depends on gbdi_pkg.
module gbdi_front #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_mode,
  input  logic signed [15:0]  in_raw_x,
  input  logic signed [15:0]  in_raw_y,
  input  logic signed [15:0]  in_raw_z,
  input  logic [15:0]         in_dt_ticks,
  output logic                item_valid,
  input  logic                item_take,
  output gbdi_pkg::item_t     item
);

  localparam int RAW_W   = gbdi_pkg::RAW_W;
  localparam int RECIP_W = gbdi_pkg::RECIP_W;
  localparam int PROD_W  = RAW_W + RECIP_W;
  localparam int QLO     = gbdi_pkg::RECIP_SHIFT;
  localparam int QHI     = gbdi_pkg::RECIP_SHIFT + gbdi_pkg::QMAG_W - 1;

  // ceil(2^31 / N): exact floor(256*x/N) for |x| <= 2^15 after >> 23
  localparam longint unsigned RECIP_WIDE =
    ((64'd1 << (gbdi_pkg::RECIP_SHIFT + gbdi_pkg::Q_SHIFT)) + 64'(CAL_SAMPLES) - 64'd1)
    / 64'(CAL_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

  logic                                   s1_valid_r, s1_valid_nxt;
  logic [1:0]                             s1_mode_r;
  logic [gbdi_pkg::AXES-1:0][RAW_W-1:0]   s1_raw_r;
  logic [gbdi_pkg::DT_W-1:0]              s1_dt_r;
  logic                                   s2_valid_r, s2_valid_nxt;
  gbdi_pkg::item_t                        s2_item_r, s2_item_nxt;

  logic s2_load, s1_adv, in_xfer;
  logic [PROD_W-1:0] prod [gbdi_pkg::AXES];

  assign s2_load  = !s2_valid_r || item_take;
  assign s1_adv   = s1_valid_r && s2_load;
  assign in_stall = s1_valid_r && !s2_load;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign s2_valid_nxt = s1_adv ? 1'b1 : (item_take ? 1'b0 : s2_valid_r);

  genvar g;
  generate
    for (g = 0; g < gbdi_pkg::AXES; g++) begin : g_axis
      assign prod[g] = PROD_W'(gbdi_pkg::raw_mag(s1_raw_r[g])) * PROD_W'(RECIP);
      assign s2_item_nxt.q_mag[g] = prod[g][QHI:QLO];
    end
  endgenerate

  assign s2_item_nxt.mode = s1_mode_r;
  assign s2_item_nxt.raw  = s1_raw_r;
  assign s2_item_nxt.dt   = s1_dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_mode_r   <= in_mode;
      s1_raw_r[0] <= in_raw_x;
      s1_raw_r[1] <= in_raw_y;
      s1_raw_r[2] <= in_raw_z;
      s1_dt_r     <= in_dt_ticks;
    end
    if (s1_adv) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign item_valid = s2_valid_r;
  assign item       = s2_item_r;

endmodule

@@ hdl/gbdi_core.sv @@
// Core stage: calibration accumulation, bias/deadband correction, saturating
// angle integration and the result register. Depends on gbdi_pkg and the macros header.
`include "gyro_bias_deadband_angle_integrator_macros.svh"

module gbdi_core #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [22:0]         cfg_wr_data,
  input  logic                item_valid,
  output logic                item_take,
  input  gbdi_pkg::item_t     item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [24:0]  out_rate_x_q8,
  output logic signed [24:0]  out_rate_y_q8,
  output logic signed [24:0]  out_rate_z_q8,
  output logic signed [55:0]  out_angle_x_acc,
  output logic signed [55:0]  out_angle_y_acc,
  output logic signed [55:0]  out_angle_z_acc,
  output logic                out_calibrated
);

  localparam int AXES    = gbdi_pkg::AXES;
  localparam int RAW_W   = gbdi_pkg::RAW_W;
  localparam int DT_W    = gbdi_pkg::DT_W;
  localparam int Q_SHIFT = gbdi_pkg::Q_SHIFT;
  localparam int BIAS_W  = gbdi_pkg::BIAS_W;
  localparam int RATE_W  = gbdi_pkg::RATE_W;
  localparam int ACC_W   = gbdi_pkg::ACC_W;
  localparam int DB_W    = gbdi_pkg::DB_W;
  localparam int QMAG_W  = gbdi_pkg::QMAG_W;
  localparam int QACC_W  = gbdi_pkg::QACC_W;
  localparam int MPROD_W = RATE_W + DT_W + 1;
  localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int REM_W   = $clog2(CAL_SAMPLES + 1);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);
  localparam logic [REM_W-1:0] N_REM    = REM_W'(CAL_SAMPLES);
  localparam logic [REM_W:0]   N_EXT    = (REM_W + 1)'(CAL_SAMPLES);

  // configuration and state
  logic [DB_W-1:0]           deadband_r;
  logic [CNT_W-1:0]          cal_count_r, cal_count_nxt;
  logic signed [QACC_W-1:0]  qacc_r [AXES];
  logic signed [QACC_W-1:0]  qacc_nxt [AXES];
  logic [REM_W-1:0]          rem_r [AXES];
  logic [REM_W-1:0]          rem_nxt [AXES];
  logic signed [BIAS_W-1:0]  bias_r [AXES];
  logic signed [BIAS_W-1:0]  bias_nxt [AXES];
  logic signed [ACC_W-1:0]   angle_r [AXES];
  logic signed [ACC_W-1:0]   angle_nxt [AXES];
  logic                      cal_done_r, cal_done_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [RATE_W-1:0]  out_rate_r [AXES];
  logic signed [RATE_W-1:0]  out_rate_nxt [AXES];
  logic signed [ACC_W-1:0]   out_angle_r [AXES];
  logic signed [ACC_W-1:0]   out_angle_nxt [AXES];
  logic                      out_cal_r;

  // per-axis candidates
  logic signed [QACC_W-1:0]  qsum_new [AXES];
  logic [REM_W-1:0]          rem_new [AXES];
  logic signed [BIAS_W-1:0]  bias_new [AXES];
  logic signed [RATE_W-1:0]  rate_new [AXES];
  logic signed [ACC_W-1:0]   angle_upd [AXES];

  logic signed [DT_W:0]      dt_s;

  assign item_take     = item_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = item_take ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  assign dt_s          = {1'b0, item.dt};

  genvar g;
  generate
    for (g = 0; g < AXES; g++) begin : g_axis
      logic [RAW_W-1:0]              raw, mag;
      logic                          neg;
      logic [QMAG_W-1:0]             q, dvd, qn;
      logic [REM_W-1:0]              rm, b;
      logic signed [QACC_W-1:0]      qs, a, bfin;
      logic [REM_W:0]                rsum;
      logic                          carry;
      logic signed [BIAS_W-1:0]      d;
      logic signed [RATE_W-1:0]      diff;
      logic [RATE_W-1:0]             dmag;
      logic signed [MPROD_W-1:0]     mprod;
      logic signed [ACC_W:0]         asum;

      assign raw = item.raw[g];
      assign mag = gbdi_pkg::raw_mag(raw);
      assign neg = raw[RAW_W-1];

      // Calibration: keep the running sum as quotient/remainder of N in floor form,
      // so the bias falls out of the last sample without a divider.
      assign q   = item.q_mag[g];
      assign dvd = {mag, {Q_SHIFT{1'b0}}};
      assign qn  = q * QMAG_W'(CAL_SAMPLES);
      assign rm  = REM_W'(dvd - qn);
      assign qs  = {1'b0, q};
      assign a   = neg ? ((rm == '0) ? -qs : ~qs) : qs;
      assign b   = (neg && rm != '0) ? N_REM - rm : rm;

      assign rsum  = {1'b0, rem_r[g]} + {1'b0, b};
      assign carry = (rsum >= N_EXT);
      assign rem_new[g]  = carry ? REM_W'(rsum - N_EXT) : rsum[REM_W-1:0];
      assign qsum_new[g] = qacc_r[g] + a + {{(QACC_W-1){1'b0}}, carry};

      // floor to truncation toward zero
      assign bfin = (qsum_new[g][QACC_W-1] && rem_new[g] != '0) ?
                    qsum_new[g] + QACC_W'(1) : qsum_new[g];
      assign bias_new[g] = bfin[BIAS_W-1:0];

      // Measure: bias removal, deadband, rate * ticks, saturating accumulate
      assign d    = {raw, {Q_SHIFT{1'b0}}};
      assign diff = {d[BIAS_W-1], d} - {bias_r[g][BIAS_W-1], bias_r[g]};
      assign dmag = diff[RATE_W-1] ? (~diff + 1'b1) : diff;
      assign rate_new[g] = (dmag < {{(RATE_W-DB_W){1'b0}}, deadband_r}) ? '0 : diff;

      assign mprod = rate_new[g] * dt_s;
      assign asum  = {angle_r[g][ACC_W-1], angle_r[g]}
                   + {{(ACC_W+1-MPROD_W){mprod[MPROD_W-1]}}, mprod};
      assign angle_upd[g] = (asum[ACC_W] != asum[ACC_W-1]) ?
                            (asum[ACC_W] ? gbdi_pkg::ACC_MIN : gbdi_pkg::ACC_MAX) :
                            asum[ACC_W-1:0];
    end
  endgenerate

  always_comb begin
    cal_count_nxt = cal_count_r;
    cal_done_nxt  = cal_done_r;
    for (int i = 0; i < AXES; i++) begin
      qacc_nxt[i]      = qacc_r[i];
      rem_nxt[i]       = rem_r[i];
      bias_nxt[i]      = bias_r[i];
      angle_nxt[i]     = angle_r[i];
      out_rate_nxt[i]  = '0;
      out_angle_nxt[i] = angle_r[i];
    end
    if (item_take) begin
      unique case (item.mode)
        gbdi_pkg::MODE_CAL: begin
          if (cal_count_r == CNT_LAST) begin
            cal_count_nxt = '0;
            cal_done_nxt  = 1'b1;
            for (int i = 0; i < AXES; i++) begin
              bias_nxt[i] = bias_new[i];
              qacc_nxt[i] = '0;
              rem_nxt[i]  = '0;
            end
          end else begin
            cal_count_nxt = cal_count_r + 1'b1;
            for (int i = 0; i < AXES; i++) begin
              qacc_nxt[i] = qsum_new[i];
              rem_nxt[i]  = rem_new[i];
            end
          end
        end
        gbdi_pkg::MODE_MEAS: begin
          for (int i = 0; i < AXES; i++) begin
            out_rate_nxt[i]  = rate_new[i];
            angle_nxt[i]     = angle_upd[i];
            out_angle_nxt[i] = angle_upd[i];
          end
        end
        gbdi_pkg::MODE_READ: begin
          for (int i = 0; i < AXES; i++) begin
            angle_nxt[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r  <= gbdi_pkg::DEADBAND_RST;
      cal_count_r <= '0;
      cal_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        qacc_r[i]  <= '0;
        rem_r[i]   <= '0;
        bias_r[i]  <= '0;
        angle_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        deadband_r <= cfg_wr_data;
      end
      cal_count_r <= cal_count_nxt;
      cal_done_r  <= cal_done_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < AXES; i++) begin
        qacc_r[i]  <= qacc_nxt[i];
        rem_r[i]   <= rem_nxt[i];
        bias_r[i]  <= bias_nxt[i];
        angle_r[i] <= angle_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_cal_r <= cal_done_nxt;
      for (int i = 0; i < AXES; i++) begin
        out_rate_r[i]  <= out_rate_nxt[i];
        out_angle_r[i] <= out_angle_nxt[i];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rate_x_q8   = out_rate_r[0];
  assign out_rate_y_q8   = out_rate_r[1];
  assign out_rate_z_q8   = out_rate_r[2];
  assign out_angle_x_acc = out_angle_r[0];
  assign out_angle_y_acc = out_angle_r[1];
  assign out_angle_z_acc = out_angle_r[2];
  assign out_calibrated  = out_cal_r;

  `GBDI_ASSERT_NOW(a_cnt_range, 1'b1, cal_count_r < CNT_W'(CAL_SAMPLES), "cal count past run length")
  `GBDI_ASSERT_NOW(a_rem_range, 1'b1, rem_r[0] < N_REM && rem_r[1] < N_REM && rem_r[2] < N_REM, "cal remainder not below run length")
  `GBDI_ASSERT_NEXT(a_read_clears, item_take && item.mode == gbdi_pkg::MODE_READ, angle_r[0] == '0 && angle_r[1] == '0 && angle_r[2] == '0, "angles not cleared after read")
  `GBDI_ASSERT_NEXT(a_take_shows, item_take, out_valid_r, "consumed item left no result")
  `GBDI_ASSERT_NEXT(a_done_sticky, cal_done_r, cal_done_r, "calibrated flag dropped")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for gyro_bias_deadband_angle_integrator: bias calibration,
// deadband, angle integration and read-and-clear, scored against a local model.
// Depends on gbdi_pkg and the RTL top level only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          AXES        = gbdi_pkg::AXES;
  localparam int          RAW_W       = gbdi_pkg::RAW_W;
  localparam int          DT_W        = gbdi_pkg::DT_W;
  localparam int          RATE_W      = gbdi_pkg::RATE_W;
  localparam int          ACC_W       = gbdi_pkg::ACC_W;
  localparam int          DB_W        = gbdi_pkg::DB_W;
  localparam int          CAL_RUN     = 100;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam longint      ANGLE_MAX   = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint      ANGLE_MIN   = -ANGLE_MAX - 1;

  typedef struct packed {
    logic [AXES-1:0][RATE_W-1:0] rate;
    logic [AXES-1:0][ACC_W-1:0]  angle;
    logic                        calibrated;
  } gyro_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [DB_W-1:0]     cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_mode;
  logic signed [15:0]  in_raw_x;
  logic signed [15:0]  in_raw_y;
  logic signed [15:0]  in_raw_z;
  logic [15:0]         in_dt_ticks;
  logic                out_valid;
  logic                out_stall;
  logic signed [24:0]  out_rate_x_q8;
  logic signed [24:0]  out_rate_y_q8;
  logic signed [24:0]  out_rate_z_q8;
  logic signed [55:0]  out_angle_x_acc;
  logic signed [55:0]  out_angle_y_acc;
  logic signed [55:0]  out_angle_z_acc;
  logic                out_calibrated;

  // Model state
  int unsigned  deadband_now = 32'(gbdi_pkg::DEADBAND_RST);
  int           cal_sum [AXES] = '{0, 0, 0};
  int           cal_count = 0;
  longint       bias_now [AXES] = '{0, 0, 0};
  longint       angle_now [AXES] = '{0, 0, 0};
  bit           cal_done_now = 1'b0;

  gyro_result_t expected_results [$];
  int           mismatches = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_requests = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  gyro_bias_deadband_angle_integrator #(
    .CAL_SAMPLES(CAL_RUN)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_raw_x(in_raw_x),
    .in_raw_y(in_raw_y),
    .in_raw_z(in_raw_z),
    .in_dt_ticks(in_dt_ticks),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rate_x_q8(out_rate_x_q8),
    .out_rate_y_q8(out_rate_y_q8),
    .out_rate_z_q8(out_rate_z_q8),
    .out_angle_x_acc(out_angle_x_acc),
    .out_angle_y_acc(out_angle_y_acc),
    .out_angle_z_acc(out_angle_z_acc),
    .out_calibrated(out_calibrated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Advances the model by one accepted transfer and returns the result it implies.
  function automatic gyro_result_t integrate_item(input logic [1:0] mode,
                                                  input logic [AXES-1:0][RAW_W-1:0] raw,
                                                  input logic [DT_W-1:0] dt);
    gyro_result_t res;
    longint       corr;
    longint       total;
    res = '0;
    case (mode)
      gbdi_pkg::MODE_CAL: begin
        for (int a = 0; a < AXES; a++) cal_sum[a] += int'($signed(raw[a]));
        cal_count++;
        if (cal_count >= CAL_RUN) begin
          for (int a = 0; a < AXES; a++) begin
            bias_now[a] = (longint'(cal_sum[a]) * 256) / CAL_RUN;
            cal_sum[a] = 0;
          end
          cal_count = 0;
          cal_done_now = 1'b1;
        end
      end
      gbdi_pkg::MODE_MEAS: begin
        for (int a = 0; a < AXES; a++) begin
          corr = longint'($signed(raw[a])) * 256 - bias_now[a];
          if ((corr < 0 ? -corr : corr) < longint'(deadband_now)) corr = 0;
          total = angle_now[a] + corr * longint'(dt);
          if (total > ANGLE_MAX) total = ANGLE_MAX;
          else if (total < ANGLE_MIN) total = ANGLE_MIN;
          angle_now[a] = total;
          res.rate[a] = corr[RATE_W-1:0];
        end
      end
      gbdi_pkg::MODE_READ: begin
        // reported value is the one before the clear
        for (int a = 0; a < AXES; a++) begin
          res.angle[a] = angle_now[a][ACC_W-1:0];
          angle_now[a] = 0;
        end
      end
      default: ;
    endcase
    if (mode != gbdi_pkg::MODE_READ)
      for (int a = 0; a < AXES; a++) res.angle[a] = angle_now[a][ACC_W-1:0];
    res.calibrated = cal_done_now;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, what, want, got);
  endtask

  // Result checker
  always @(posedge clk) begin
    gyro_result_t                want;
    logic [AXES-1:0][RATE_W-1:0] got_rate;
    logic [AXES-1:0][ACC_W-1:0]  got_angle;
    if (rst_n && out_valid && !out_stall) begin
      got_rate  = {out_rate_z_q8, out_rate_y_q8, out_rate_x_q8};
      got_angle = {out_angle_z_acc, out_angle_y_acc, out_angle_x_acc};
      if (expected_results.size() == 0) begin
        note_mismatch("result transfer with nothing pending", 64'sd0, 64'sd0);
      end else begin
        want = expected_results.pop_front();
        for (int a = 0; a < AXES; a++) begin
          if (got_rate[a] !== want.rate[a])
            note_mismatch($sformatf("rate axis %0d", a), 64'($signed(want.rate[a])),
                          64'($signed(got_rate[a])));
          if (got_angle[a] !== want.angle[a])
            note_mismatch($sformatf("angle axis %0d", a), 64'($signed(want.angle[a])),
                          64'($signed(got_angle[a])));
        end
        if (out_calibrated !== want.calibrated)
          note_mismatch("calibrated", 64'(want.calibrated), 64'(out_calibrated));
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < rx_idle_pct);
    end
  end

  // Offers one item, waits for its transfer and queues the predicted result.
  // Valid stays high afterwards so back-to-back items never drop it.
  task automatic send_item(input logic [1:0] mode, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] z,
                           input logic [15:0] dt);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_raw_x    <= x;
    in_raw_y    <= y;
    in_raw_z    <= z;
    in_dt_ticks <= dt;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(integrate_item(mode, {z, y, x}, dt));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // three-stage pipeline, plus margin
    repeat (4) @(posedge clk);
  endtask

  task automatic write_deadband(input logic [DB_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    deadband_now = 32'(value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [1:0]                  mode;
    logic [AXES-1:0][RAW_W-1:0]  raw;
    logic [DT_W-1:0]             dt;
    int                          pick;
    int                          val;
    pick = int'($urandom_range(99));
    if (pick < 40)      mode = gbdi_pkg::MODE_MEAS;
    else if (pick < 75) mode = gbdi_pkg::MODE_CAL;
    else if (pick < 92) mode = gbdi_pkg::MODE_READ;
    else                mode = MODE_UNUSED;
    for (int a = 0; a < AXES; a++) begin
      if ($urandom_range(1)) begin
        raw[a] = 16'($urandom);
      end else begin
        // near zero, where the deadband decides
        val = int'($urandom_range(600)) - 300;
        raw[a] = val[15:0];
      end
    end
    dt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(50));
    send_item(mode, raw[0], raw[1], raw[2], dt);
  endtask

  task automatic test_directed();
    tx_idle_pct = 21;
    rx_idle_pct = 70;
    send_item(MODE_UNUSED, 16'sh8000, 16'sh7FFF, -16'sd1, 16'hFFFF);
    // uncalibrated: bias still zero
    send_item(gbdi_pkg::MODE_MEAS, 16'sh7FFF, 16'sh8000, '0, 16'hFFFF);
    send_item(gbdi_pkg::MODE_MEAS, 16'sd114, -16'sd115, 16'sd1, 16'd1);
    send_item(gbdi_pkg::MODE_MEAS, 16'sh8000, 16'sh7FFF, -16'sd1, '0);
    send_item(gbdi_pkg::MODE_READ, 16'sd1, 16'sd2, 16'sd3, 16'd4);
    send_item(gbdi_pkg::MODE_READ, 16'sh7FFF, 16'sh8000, -16'sd1, 16'hFFFF);
    send_item(MODE_UNUSED, '0, '0, '0, '0);
    // magnitude equal to the deadband passes, one below is zeroed
    write_deadband(23'd25600);
    send_item(gbdi_pkg::MODE_MEAS, 16'sd100, -16'sd100, 16'sd99, 16'd3);
    send_item(gbdi_pkg::MODE_MEAS, -16'sd99, 16'sd101, -16'sd101, 16'd7);
    write_deadband('0);
    send_item(gbdi_pkg::MODE_MEAS, '0, 16'sd1, -16'sd1, 16'hFFFF);
    write_deadband(23'h7FFFFF);
    send_item(gbdi_pkg::MODE_MEAS, 16'sh7FFF, 16'sh8000, '0, 16'd2);
    send_item(gbdi_pkg::MODE_READ, '0, '0, '0, '0);
    write_deadband(gbdi_pkg::DEADBAND_RST);
  endtask

  task automatic test_calibration();
    tx_idle_pct = 70;
    rx_idle_pct = 21;
    for (int i = 0; i < CAL_RUN; i++) begin
      send_item(gbdi_pkg::MODE_CAL, 16'sh8000, 16'sh7FFF, 16'($urandom), 16'($urandom));
      if (i % 25 == 0) send_item(gbdi_pkg::MODE_MEAS, '0, '0, '0, 16'd10);
    end
    send_item(gbdi_pkg::MODE_MEAS, '0, '0, '0, 16'd100);
    send_item(gbdi_pkg::MODE_MEAS, 16'sh7FFF, 16'sh8000, '0, 16'd1);
    // second run replaces the bias; reads and unused items mid-run leave the count alone
    for (int i = 0; i < CAL_RUN; i++) begin
      send_item(gbdi_pkg::MODE_CAL, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
      if (i % 30 == 0) send_item(MODE_UNUSED, 16'($urandom), '0, '0, 16'($urandom));
      if (i % 30 == 15) send_item(gbdi_pkg::MODE_READ, '0, '0, '0, '0);
    end
    repeat (5) send_item(gbdi_pkg::MODE_MEAS, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'd500);
    send_item(gbdi_pkg::MODE_READ, '0, '0, '0, '0);
  endtask

  task automatic test_full_scale();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // bias x at its negative extreme, y at its positive one, z zero
    for (int i = 0; i < CAL_RUN; i++)
      send_item(gbdi_pkg::MODE_CAL, 16'sh8000, 16'sh7FFF, '0, '0);
    send_item(gbdi_pkg::MODE_READ, '0, '0, '0, '0);
    // largest rates of both signs at the longest tick count
    repeat (20) send_item(gbdi_pkg::MODE_MEAS, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF);
    send_item(gbdi_pkg::MODE_READ, '0, '0, '0, '0);
    send_item(gbdi_pkg::MODE_MEAS, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd1);
    send_item(gbdi_pkg::MODE_READ, '0, '0, '0, '0);
    wait_idle();
  endtask

  task automatic test_random();
    int pct_pairs [3][2] = '{'{21, 70}, '{70, 21}, '{0, 0}};
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       write_deadband(23'($urandom_range(60000)));
        1:       write_deadband(23'($urandom_range(23'h7FFFFF)));
        default: write_deadband(gbdi_pkg::DEADBAND_RST);
      endcase
      tx_idle_pct = pct_pairs[phase][0];
      rx_idle_pct = pct_pairs[phase][1];
      repeat (140) send_random_item();
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (2) begin
      hold_requests++;
      repeat (40) send_random_item();
      wait_idle();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_mode     <= gbdi_pkg::MODE_CAL;
    in_raw_x    <= '0;
    in_raw_y    <= '0;
    in_raw_z    <= '0;
    in_dt_ticks <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_calibration();
    test_full_scale();
    test_random();
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/gbdi_pkg.sv
hdl/gbdi_front.sv
hdl/gbdi_core.sv
hdl/gyro_bias_deadband_angle_integrator.sv
tb/tb.sv
